// ----- design/dlpg_pkg.sv -----
// dlpg_pkg: shared types and codes for the dda line point generator
// holds the request and point payload structs, request codes and the queue command type
// no dependencies

package dlpg_pkg;

    // width of coordinates on the ports
    localparam int IO_COORD_BITS = 10;

    // reset value of the window height register
    localparam logic [IO_COORD_BITS-1:0] HEIGHT_RESET = 10'd480;

    // request codes on the input port
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_END   = 2'd1;
    localparam logic [1:0] REQ_NEXT  = 2'd2;

    // command kinds held in the queue between front and back
    typedef enum logic [1:0] {
        CMD_START,
        CMD_END,
        CMD_NEXT
    } t_cmd;

    // one input request
    typedef struct packed {
        logic [1:0]               req_type;
        logic [IO_COORD_BITS-1:0] coord_x;
        logic [IO_COORD_BITS-1:0] coord_y;
    } t_req;

    // one emitted point
    typedef struct packed {
        logic [IO_COORD_BITS-1:0] point_x;
        logic [IO_COORD_BITS-1:0] point_y;
        logic                     last_point;
    } t_point;

endpackage

// ----- design/dlpg_front.sv -----
// dlpg_front: request intake for the dda line point generator
// holds the window height register, flips y and classifies requests into queue commands
// depends on dlpg_pkg

module dlpg_front
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [IO_COORD_BITS-1:0] i_cfg_wdata,
    input  logic                    i_start,
    input  t_req                    i_req,
    input  logic                    i_full,
    output logic                    o_busy,
    output logic                    o_push,
    output logic [2*COORD_BITS+1:0] o_push_data
);

    logic [IO_COORD_BITS-1:0] r_window_height;
    logic [COORD_BITS-1:0]    height;
    logic [COORD_BITS-1:0]    cx;
    logic [COORD_BITS-1:0]    cy_raw;
    logic [COORD_BITS-1:0]    cy;
    logic                     accept;
    t_cmd                     cmd;
    logic                     keep;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            r_window_height <= i_cfg_wdata;
        end
    end

    // coordinates at internal width, y flipped and clamped at zero
    always_comb begin
        height = COORD_BITS'(r_window_height);
        cx     = COORD_BITS'(i_req.coord_x);
        cy_raw = COORD_BITS'(i_req.coord_y);
        cy     = (cy_raw > height) ? '0 : (height - cy_raw);
    end

    // classify the request, the unused code is dropped
    always_comb begin
        cmd  = CMD_NEXT;
        keep = 1'b0;
        unique case (i_req.req_type)
            REQ_START: begin
                cmd  = CMD_START;
                keep = 1'b1;
            end
            REQ_END: begin
                cmd  = CMD_END;
                keep = 1'b1;
            end
            REQ_NEXT: begin
                cmd  = CMD_NEXT;
                keep = 1'b1;
            end
            default: begin
                cmd  = CMD_NEXT;
                keep = 1'b0;
            end
        endcase
    end

    // transfer into the queue
    assign o_busy      = i_full;
    assign accept      = i_start && !i_full;
    assign o_push      = accept && keep;
    assign o_push_data = {cmd, cx, cy};

endmodule

// ----- design/dlpg_queue.sv -----
// dlpg_queue: two-entry command queue between front and back
// plain register fifo with a fill count, generic in the entry width
// depends on nothing

module dlpg_queue #(
    parameter int WIDTH = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end else begin
                r_count <= r_count;
            end
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // no transfer into a full queue, none out of an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

endmodule

// ----- design/dlpg_back.sv -----
// dlpg_back: line setup and point stepping for the dda line point generator
// holds start point, position, increments, point count and a restoring divider
// depends on dlpg_pkg

module dlpg_back
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [2*COORD_BITS+1:0] i_head,
    output logic                    o_pop,
    output logic                    o_strobe,
    output t_point                  o_result
);

    localparam int CB     = COORD_BITS;
    localparam int POS_W  = COORD_BITS + FRAC_BITS;
    localparam int INC_W  = FRAC_BITS + 2;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int ITER_W = $clog2(FRAC_BITS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

    t_state                   r_state;
    logic [CB-1:0]            r_start_x;
    logic [CB-1:0]            r_start_y;
    logic [POS_W-1:0]         r_pos_x;
    logic [POS_W-1:0]         r_pos_y;
    logic signed [INC_W-1:0]  r_inc_x;
    logic signed [INC_W-1:0]  r_inc_y;
    logic [CB:0]              r_points_left;
    logic [CB-1:0]            r_step;
    logic [CB:0]              r_rem_x;
    logic [CB:0]              r_rem_y;
    logic [QUO_W-1:0]         r_quo_x;
    logic [QUO_W-1:0]         r_quo_y;
    logic                     r_neg_x;
    logic                     r_neg_y;
    logic [ITER_W-1:0]        r_iter;
    logic                     r_strobe;
    t_point                   r_point;

    t_cmd                     cmd;
    logic [CB-1:0]            ent_x;
    logic [CB-1:0]            ent_y;
    logic signed [CB:0]       dx;
    logic signed [CB:0]       dy;
    logic [CB:0]              adx;
    logic [CB:0]              ady;
    logic [CB-1:0]            mag_x;
    logic [CB-1:0]            mag_y;
    logic [CB-1:0]            step;
    logic [CB:0]              step_ext;
    logic [CB:0]              t_x;
    logic [CB:0]              t_y;
    logic                     bit_x;
    logic                     bit_y;
    logic [QUO_W-1:0]         qf_x;
    logic [QUO_W-1:0]         qf_y;
    logic signed [INC_W-1:0]  qs_x;
    logic signed [INC_W-1:0]  qs_y;
    logic [POS_W-1:0]         inc_ext_x;
    logic [POS_W-1:0]         inc_ext_y;

    // split the queue head
    always_comb begin
        cmd   = t_cmd'(i_head[2*CB+1 -: 2]);
        ent_x = i_head[2*CB-1:CB];
        ent_y = i_head[CB-1:0];
    end

    // line setup: deltas, magnitudes and the major-axis step count
    always_comb begin
        dx    = $signed({1'b0, ent_x}) - $signed({1'b0, r_start_x});
        dy    = $signed({1'b0, ent_y}) - $signed({1'b0, r_start_y});
        adx   = dx[CB] ? -dx : dx;
        ady   = dy[CB] ? -dy : dy;
        mag_x = adx[CB-1:0];
        mag_y = ady[CB-1:0];
        step  = (mag_x > mag_y) ? mag_x : mag_y;
    end

    // one quotient bit per cycle, the first bit compares without a shift
    always_comb begin
        step_ext = {1'b0, r_step};
        t_x      = (r_iter == '0) ? r_rem_x : {r_rem_x[CB-1:0], 1'b0};
        t_y      = (r_iter == '0) ? r_rem_y : {r_rem_y[CB-1:0], 1'b0};
        bit_x    = (t_x >= step_ext);
        bit_y    = (t_y >= step_ext);
        qf_x     = {r_quo_x[QUO_W-2:0], bit_x};
        qf_y     = {r_quo_y[QUO_W-2:0], bit_y};
        qs_x     = {1'b0, qf_x};
        qs_y     = {1'b0, qf_y};
    end

    // increments sign-extended to the position width
    always_comb begin
        inc_ext_x = {{(POS_W-INC_W){r_inc_x[INC_W-1]}}, r_inc_x};
        inc_ext_y = {{(POS_W-INC_W){r_inc_y[INC_W-1]}}, r_inc_y};
    end

    assign o_pop = (r_state == ST_IDLE) && i_valid;

    // sequencer, line state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_pos_x       <= '0;
            r_pos_y       <= '0;
            r_inc_x       <= '0;
            r_inc_y       <= '0;
            r_points_left <= '0;
            r_iter        <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        unique case (cmd)
                            CMD_START: begin
                                r_start_x <= ent_x;
                                r_start_y <= ent_y;
                            end
                            CMD_END: begin
                                r_pos_x       <= {r_start_x, {FRAC_BITS{1'b0}}};
                                r_pos_y       <= {r_start_y, {FRAC_BITS{1'b0}}};
                                r_points_left <= {1'b0, step};
                                r_step        <= step;
                                r_rem_x       <= {1'b0, mag_x};
                                r_rem_y       <= {1'b0, mag_y};
                                r_quo_x       <= '0;
                                r_quo_y       <= '0;
                                r_neg_x       <= dx[CB];
                                r_neg_y       <= dy[CB];
                                r_iter        <= '0;
                                if (step == '0) begin
                                    // degenerate line: no points, zero increments
                                    r_inc_x <= '0;
                                    r_inc_y <= '0;
                                end else begin
                                    r_state <= ST_DIV;
                                end
                            end
                            CMD_NEXT: begin
                                if (r_points_left != '0) begin
                                    r_strobe           <= 1'b1;
                                    r_point.point_x    <= IO_COORD_BITS'(r_pos_x[POS_W-1:FRAC_BITS]);
                                    r_point.point_y    <= IO_COORD_BITS'(r_pos_y[POS_W-1:FRAC_BITS]);
                                    r_point.last_point <= (r_points_left == (CB+1)'(1));
                                    r_pos_x            <= r_pos_x + inc_ext_x;
                                    r_pos_y            <= r_pos_y + inc_ext_y;
                                    r_points_left      <= r_points_left - (CB+1)'(1);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    r_rem_x <= bit_x ? (t_x - step_ext) : t_x;
                    r_rem_y <= bit_y ? (t_y - step_ext) : t_y;
                    r_quo_x <= qf_x;
                    r_quo_y <= qf_y;
                    r_iter  <= r_iter + ITER_W'(1);
                    if (r_iter == ITER_W'(FRAC_BITS)) begin
                        r_inc_x <= r_neg_x ? -qs_x : qs_x;
                        r_inc_y <= r_neg_y ? -qs_y : qs_y;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_point;

    // a point is only emitted from a line that still had points
    a_emit_needs_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ($past(r_points_left) != '0))
        else $error("point emitted with no points left");

    // the final point leaves the count at zero
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_point.last_point) |-> (r_points_left == '0))
        else $error("last point flagged while points remain");

    // the divider never runs on a zero step
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_step != '0))
        else $error("divider running with zero step");

    // no point leaves while increments are being worked out
    a_no_emit_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !r_strobe)
        else $error("point emitted during line setup");

endmodule

// ----- design/dda_line_point_generator.sv -----
// dda_line_point_generator: top level of the dda line point generator
// ties together request front, two-entry command queue and stepping back end
// depends on dlpg_pkg, dlpg_front, dlpg_queue, dlpg_back

// A request is taken at a rising edge with start high and busy low; busy is high only
// while the two-entry command queue is full. Start-point and next-point requests are
// handled back to back by the back end. A next-point request shows its point on o_result
// with o_strobe high for exactly one cycle; with nothing waiting ahead of it that cycle
// begins at the edge after it is taken, and the receiver cannot stall it. An end-point
// request with a nonzero step holds the back end while the restoring divider forms both
// increments one quotient bit per cycle; requests taken meanwhile wait in the queue.
// Request code 3 is taken and dropped. The window height register is written at any
// edge with i_cfg_we high and is used when a request is taken.

module dda_line_point_generator
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [IO_COORD_BITS-1:0] i_cfg_wdata,
    input  logic                     start,
    input  t_req                     i_req,
    output logic                     busy,
    output logic                     o_strobe,
    output t_point                   o_result
);

    localparam int ENTRY_W = 2 * COORD_BITS + 2;

    logic               full;
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic               head_valid;
    logic [ENTRY_W-1:0] head;

    // request intake
    dlpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start     (start),
        .i_req       (i_req),
        .i_full      (full),
        .o_busy      (busy),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // command queue
    dlpg_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (full),
        .o_valid     (head_valid),
        .o_head      (head)
    );

    // line setup and stepping
    dlpg_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ----- tb/dda_line_point_generator_test.sv -----
// dda_line_point_generator_test: self-checking testbench for the dda line point generator
// directed request table, then random line sequences, checked against a line stepping predictor
// depends on dlpg_pkg and dda_line_point_generator

module dda_line_point_generator_test
    import dlpg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC         = 16;
    localparam int          POS_BITS     = IO_COORD_BITS + FRAC;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam int          PHASE_ITEMS  = 390;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          CYCLE_LIMIT  = 500000;

    // how a directed row is checked
    typedef enum logic [1:0] {
        BY_MODEL,
        WANT_NONE,
        WANT_POINT
    } t_check;

    typedef struct packed {
        t_req   req;
        t_check chk;
        t_point want;
    } t_script_row;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [IO_COORD_BITS-1:0] i_cfg_wdata = '0;
    logic                     start       = 1'b0;
    t_req                     i_req       = '0;
    logic                     busy;
    logic                     o_strobe;
    t_point                   o_result;

    // line stepping state as the block should hold it
    logic [IO_COORD_BITS-1:0] win_height = HEIGHT_RESET;
    logic [IO_COORD_BITS-1:0] org_x      = '0;
    logic [IO_COORD_BITS-1:0] org_y      = '0;
    logic [POS_BITS-1:0]      pos_x_fx   = '0;
    logic [POS_BITS-1:0]      pos_y_fx   = '0;
    logic signed [FRAC+1:0]   inc_x_fx   = '0;
    logic signed [FRAC+1:0]   inc_y_fx   = '0;
    logic [IO_COORD_BITS:0]   pts_left   = '0;

    t_point      points_due[$];
    t_script_row script[$];
    int          error_count    = 0;
    int          cycle_count    = 0;
    int          accepted_count = 0;
    bit          calm           = 1'b0;
    t_point      got_pt;
    t_point      want_pt;

    dda_line_point_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("dda_line_point_generator regression: fail");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // vertical flip, saturated at zero
    function automatic logic [IO_COORD_BITS-1:0] flip_row(input logic [IO_COORD_BITS-1:0] y);
        return (y > win_height) ? '0 : win_height - y;
    endfunction

    // signed per-point increment, quotient of magnitudes rounded toward zero
    function automatic logic signed [FRAC+1:0] slope_step(input int d, input int steps);
        int mag;
        int q;
        if (steps == 0)
            return '0;
        mag = (d < 0) ? -d : d;
        q   = (mag << FRAC) / steps;
        return (FRAC+2)'((d < 0) ? -q : q);
    endfunction

    // advance the line state by one accepted request, give the point it emits if any
    task automatic compute_line_point(input t_req r, output bit emits, output t_point pt);
        logic [IO_COORD_BITS-1:0] end_x;
        logic [IO_COORD_BITS-1:0] end_y;
        int dx;
        int dy;
        int ax;
        int ay;
        int steps;
        emits = 1'b0;
        pt    = '0;
        case (r.req_type)
            REQ_START: begin
                org_x = r.coord_x;
                org_y = flip_row(r.coord_y);
            end
            REQ_END: begin
                end_x    = r.coord_x;
                end_y    = flip_row(r.coord_y);
                dx       = int'(end_x) - int'(org_x);
                dy       = int'(end_y) - int'(org_y);
                ax       = (dx < 0) ? -dx : dx;
                ay       = (dy < 0) ? -dy : dy;
                steps    = (ax > ay) ? ax : ay;
                inc_x_fx = slope_step(dx, steps);
                inc_y_fx = slope_step(dy, steps);
                pos_x_fx = {org_x, {FRAC{1'b0}}};
                pos_y_fx = {org_y, {FRAC{1'b0}}};
                pts_left = (IO_COORD_BITS+1)'(steps);
            end
            REQ_NEXT: begin
                if (pts_left != 0) begin
                    emits       = 1'b1;
                    pt.point_x  = pos_x_fx[POS_BITS-1:FRAC];
                    pt.point_y  = pos_y_fx[POS_BITS-1:FRAC];
                    pos_x_fx    = pos_x_fx + {{(POS_BITS-FRAC-2){inc_x_fx[FRAC+1]}}, inc_x_fx};
                    pos_y_fx    = pos_y_fx + {{(POS_BITS-FRAC-2){inc_y_fx[FRAC+1]}}, inc_y_fx};
                    pts_left    = pts_left - 1'b1;
                    pt.last_point = (pts_left == 0);
                end
            end
            default: begin
                // unused code, dropped
            end
        endcase
    endtask

    // one request transfer, with a random idle gap ahead of it outside the calm phase
    task automatic submit(input t_req r, input t_check chk, input t_point want);
        bit     emits;
        t_point pt;
        if (!calm) begin
            while ($urandom_range(0, 99) < 27) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (r.req_type != REQ_UNUSED && !(r.req_type == REQ_NEXT && pts_left == 0))
            accepted_count++;
        compute_line_point(r, emits, pt);
        if (chk == WANT_POINT)
            points_due.push_back(want);
        else if (chk == BY_MODEL && emits)
            points_due.push_back(pt);
    endtask

    function automatic t_req make_req(input logic [1:0] kind, input int x, input int y);
        t_req r;
        r.req_type = kind;
        r.coord_x  = IO_COORD_BITS'(x);
        r.coord_y  = IO_COORD_BITS'(y);
        return r;
    endfunction

    function automatic t_script_row plan(input logic [1:0] kind, input int x, input int y,
                                         input t_check chk, input int px = 0,
                                         input int py = 0, input int lp = 0);
        t_script_row row;
        row.req             = make_req(kind, x, y);
        row.chk             = chk;
        row.want.point_x    = IO_COORD_BITS'(px);
        row.want.point_y    = IO_COORD_BITS'(py);
        row.want.last_point = 1'(lp);
        return row;
    endfunction

    function automatic int near_coord(input int c);
        int v;
        v = c + $urandom_range(0, 24) - 12;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v;
    endfunction

    function automatic t_req noise_req();
        return make_req(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                        $urandom_range(0, 1023));
    endfunction

    // well-formed line: start, end, then its points plus up to two spare next requests
    task automatic run_random_line();
        int sx;
        int sy;
        int n;
        sx = $urandom_range(0, 1023);
        sy = $urandom_range(0, 1023);
        submit(make_req(REQ_START, sx, sy), BY_MODEL, '0);
        if ($urandom_range(0, 19) == 0)
            submit(make_req(REQ_END, $urandom_range(0, 1023), $urandom_range(0, 1023)),
                   BY_MODEL, '0);
        else
            submit(make_req(REQ_END, near_coord(sx), near_coord(sy)), BY_MODEL, '0);
        n = pts_left + $urandom_range(0, 2);
        repeat (n) begin
            // occasional stray request in the middle of a line
            if ($urandom_range(0, 29) == 0)
                submit(noise_req(), BY_MODEL, '0);
            submit(make_req(REQ_NEXT, $urandom_range(0, 1023), $urandom_range(0, 1023)),
                   BY_MODEL, '0);
        end
    endtask

    // wait for every pending point, then for queued setup work to finish
    task automatic drain();
        start <= 1'b0;
        while (points_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_height(input logic [IO_COORD_BITS-1:0] h);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        win_height   = h;
    endtask

    // result checker, the receiver never stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            got_pt = o_result;
            if (points_due.size() == 0) begin
                flag_error($sformatf("unexpected point (%0d,%0d) last %0d",
                                     got_pt.point_x, got_pt.point_y, got_pt.last_point));
            end else begin
                want_pt = points_due.pop_front();
                if (got_pt.point_x !== want_pt.point_x)
                    flag_error($sformatf("point_x got %0d want %0d",
                                         got_pt.point_x, want_pt.point_x));
                if (got_pt.point_y !== want_pt.point_y)
                    flag_error($sformatf("point_y got %0d want %0d",
                                         got_pt.point_y, want_pt.point_y));
                if (got_pt.last_point !== want_pt.last_point)
                    flag_error($sformatf("last_point got %0d want %0d",
                                         got_pt.last_point, want_pt.last_point));
            end
        end
    end

    // stimulus
    initial begin
        logic [IO_COORD_BITS-1:0] h;

        // directed rows, window height at its reset value
        script.push_back(plan(REQ_NEXT,      0,    0, WANT_NONE));   // nothing left after reset
        script.push_back(plan(REQ_UNUSED, 1023, 1023, WANT_NONE));   // unused code dropped
        script.push_back(plan(REQ_START,     0,    0, WANT_NONE));
        script.push_back(plan(REQ_END,       0,    0, WANT_NONE));   // start equals end
        script.push_back(plan(REQ_NEXT,      0,    0, WANT_NONE));
        script.push_back(plan(REQ_START,  1023, 1023, WANT_NONE));   // flip saturates at zero
        script.push_back(plan(REQ_END,    1020, 1020, WANT_NONE));
        script.push_back(plan(REQ_NEXT,      0,    0, WANT_POINT, 1023, 0, 0));
        script.push_back(plan(REQ_NEXT,   1023, 1023, WANT_POINT, 1022, 0, 0));
        script.push_back(plan(REQ_NEXT,      0,    0, WANT_POINT, 1021, 0, 1));
        script.push_back(plan(REQ_NEXT,      0,    0, WANT_NONE));
        script.push_back(plan(REQ_START,     0,  480, WANT_NONE));
        script.push_back(plan(REQ_END,    1023,    0, WANT_NONE));   // longest line
        script.push_back(plan(REQ_NEXT,      0,    0, WANT_POINT, 0, 0, 0));
        script.push_back(plan(REQ_NEXT,      0,    0, BY_MODEL));
        script.push_back(plan(REQ_START,     5,    5, WANT_NONE));   // line keeps going
        script.push_back(plan(REQ_NEXT,      0,    0, BY_MODEL));
        script.push_back(plan(REQ_END,       7,    7, WANT_NONE));   // restarts from new start
        script.push_back(plan(REQ_NEXT,      0,    0, WANT_POINT, 5, 475, 0));
        script.push_back(plan(REQ_NEXT,      0,    0, WANT_POINT, 6, 474, 1));
        script.push_back(plan(REQ_START,    10,   10, WANT_NONE));
        script.push_back(plan(REQ_END,       7,    8, WANT_NONE));   // fractional slope
        script.push_back(plan(REQ_NEXT,      0,    0, BY_MODEL));
        script.push_back(plan(REQ_NEXT,      0,    0, BY_MODEL));
        script.push_back(plan(REQ_NEXT,      0,    0, BY_MODEL));

        // synchronous reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            submit(script[i].req, script[i].chk, script[i].want);

        // random phases, each under its own window height
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       h = 10'd1023;
                1:       h = 10'd1;
                4:       h = HEIGHT_RESET;
                default: h = IO_COORD_BITS'($urandom_range(1, 1023));
            endcase
            write_height(h);
            calm           = (ph == 2);
            accepted_count = 0;
            while (accepted_count < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85)
                    run_random_line();
                else
                    submit(noise_req(), BY_MODEL, '0);
            end
        end

        drain();
        if (error_count == 0)
            $display("dda_line_point_generator regression: pass");
        else
            $display("dda_line_point_generator regression: fail");
        $finish;
    end

endmodule
